// ----- sv/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// Substring search package
// Shared constants, the register index codes and the result type that the
// front end, the queue and the back end pass between them.
// ----------------------------------------------------------------------------
package sss_pkg;

   localparam int MAX_NEEDLE_DEF  = 32;   // default window and needle depth
   localparam int OFFSET_BITS_DEF = 16;   // default byte counter width
   localparam int LEN_BITS        = 6;    // needle_length register width
   localparam int NEEDLE_BITS     = 256;  // four 64-bit needle words
   localparam int WORD_BITS       = 64;   // one needle word
   localparam int OUT_OFF_BITS    = 16;   // match_offset field width
   localparam int QUEUE_DEPTH     = 4;    // result queue entries
   localparam int CSR_ADDR_BITS   = 6;
   localparam int CSR_DATA_BITS   = 64;

   typedef enum logic [2:0] {
      REG_NEEDLE_LEN    = 3'd0,
      REG_NEEDLE_LO     = 3'd1,
      REG_NEEDLE_MID_LO = 3'd2,
      REG_NEEDLE_MID_HI = 3'd3,
      REG_NEEDLE_HI     = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic                    found;
      logic [OUT_OFF_BITS-1:0] offset;
   } rslt_type;

endpackage

// ----- sv/sss_csr.sv -----
// ----------------------------------------------------------------------------
// Substring search configuration registers
// APB-style register file holding the needle length and the needle bytes.
// ----------------------------------------------------------------------------
module sss_csr import sss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [LEN_BITS-1:0]      len_cfg,
   output logic [NEEDLE_BITS-1:0]   needle_vec
);

   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [WORD_BITS-1:0] lo_ff, lo_in, mlo_ff, mlo_in, mhi_ff, mhi_in, hi_ff, hi_in;
   logic                 wr_en;
   reg_idx_type          idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_BITS-1:3]);

   always_comb begin
      len_in = len_ff;
      lo_in  = lo_ff;
      mlo_in = mlo_ff;
      mhi_in = mhi_ff;
      hi_in  = hi_ff;
      if (wr_en) begin
         unique case (idx)
            REG_NEEDLE_LEN:    len_in = csr_pwdata[LEN_BITS-1:0];
            REG_NEEDLE_LO:     lo_in  = csr_pwdata;
            REG_NEEDLE_MID_LO: mlo_in = csr_pwdata;
            REG_NEEDLE_MID_HI: mhi_in = csr_pwdata;
            REG_NEEDLE_HI:     hi_in  = csr_pwdata;
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_NEEDLE_LEN:    csr_prdata = CSR_DATA_BITS'(len_ff);
         REG_NEEDLE_LO:     csr_prdata = lo_ff;
         REG_NEEDLE_MID_LO: csr_prdata = mlo_ff;
         REG_NEEDLE_MID_HI: csr_prdata = mhi_ff;
         REG_NEEDLE_HI:     csr_prdata = hi_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         lo_ff  <= '0;
         mlo_ff <= '0;
         mhi_ff <= '0;
         hi_ff  <= '0;
      end else begin
         len_ff <= len_in;
         lo_ff  <= lo_in;
         mlo_ff <= mlo_in;
         mhi_ff <= mhi_in;
         hi_ff  <= hi_in;
      end
   end

   assign len_cfg    = len_ff;
   assign needle_vec = {hi_ff, mhi_ff, mlo_ff, lo_ff};

endmodule

// ----- sv/sss_front.sv -----
// ----------------------------------------------------------------------------
// Substring search front end
// Takes haystack bytes, shifts the window, counts bytes and compares the
// newest bytes against the needle; pushes each result into the queue.
// ----------------------------------------------------------------------------
module sss_front import sss_pkg::*; #(
   parameter int MAX_NEEDLE  = MAX_NEEDLE_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic [LEN_BITS-1:0]    len_cfg,
   input  logic [NEEDLE_BITS-1:0] needle_vec,
   input  logic                   queue_full,
   output logic                   push,
   output rslt_type               push_data
);

   localparam int WinBits  = 8 * MAX_NEEDLE;
   localparam int WideBits = OFFSET_BITS + OUT_OFF_BITS;
   localparam logic [LEN_BITS-1:0]    MaxLen   = LEN_BITS'(MAX_NEEDLE);
   localparam logic [OFFSET_BITS-1:0] CountMax = '1;

   logic [WinBits-1:0]     win_ff, win_in, win_shift;
   logic [OFFSET_BITS-1:0] count_ff, count_in, count_inc, offset_full;
   logic                   done_ff, done_in;
   logic [LEN_BITS-1:0]    eff_len;
   logic [WinBits-1:0]     needle_rev, needle_align;
   logic [LEN_BITS+2:0]    shamt;
   logic [MAX_NEEDLE-1:0]  mism;
   logic [WideBits-1:0]    offset_wide;
   logic                   accept, enough, hit;

   assign in_ready = ~queue_full;
   assign accept   = in_valid & in_ready;

   assign eff_len   = (len_cfg > MaxLen) ? MaxLen : len_cfg;
   assign win_shift = (win_ff << 8) | WinBits'(in_byte);
   assign count_inc = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;

   // Needle byte i has to meet window byte eff_len-1-i. Reverse the needle,
   // then shift it down so its first byte lands on window byte eff_len-1.
   always_comb begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         needle_rev[8*k +: 8] = needle_vec[8*(MAX_NEEDLE-1-k) +: 8];
      end
   end
   assign shamt        = {MaxLen - eff_len, 3'b000};
   assign needle_align = needle_rev >> shamt;

   always_comb begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         mism[k] = (LEN_BITS'(k) < eff_len) &&
                   (win_shift[8*k +: 8] != needle_align[8*k +: 8]);
      end
   end

   assign enough      = count_inc >= OFFSET_BITS'(eff_len);
   assign hit         = enough & ~|mism;
   assign offset_full = count_inc - OFFSET_BITS'(eff_len);
   assign offset_wide = WideBits'(offset_full);

   always_comb begin
      win_in           = win_ff;
      count_in         = count_ff;
      done_in          = done_ff;
      push             = 1'b0;
      push_data.found  = 1'b0;
      push_data.offset = '0;
      if (accept) begin
         if (done_ff) begin
            // A match was already reported: wait for the end of the haystack.
            if (in_last) begin
               count_in = '0;
               done_in  = 1'b0;
            end
         end else if (eff_len == '0) begin
            // An empty needle matches at offset zero on the first byte.
            push            = 1'b1;
            push_data.found = 1'b1;
            if (in_last) begin
               count_in = '0;
            end else begin
               done_in = 1'b1;
            end
         end else begin
            win_in   = win_shift;
            count_in = count_inc;
            if (hit) begin
               push             = 1'b1;
               push_data.found  = 1'b1;
               push_data.offset = offset_wide[OUT_OFF_BITS-1:0];
               if (in_last) begin
                  count_in = '0;
               end else begin
                  done_in = 1'b1;
               end
            end else if (in_last) begin
               push     = 1'b1;
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// ----- sv/sss_queue.sv -----
// ----------------------------------------------------------------------------
// Substring search result queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sss_queue import sss_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  rslt_type push_data,
   output logic     full,
   input  logic     pop,
   output rslt_type pop_data,
   output logic     empty
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PtrBits:0]   Depth   = (PtrBits+1)'(DEPTH);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

   rslt_type           slot_ff [DEPTH];
   logic [PtrBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == Depth);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/sss_back.sv -----
// ----------------------------------------------------------------------------
// Substring search back end
// Output register that drains the result queue onto the result channel.
// ----------------------------------------------------------------------------
module sss_back import sss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  rslt_type pop_data,
   output logic     pop,
   output logic     out_valid,
   input  logic     out_ready,
   output rslt_type out_data
);

   logic     valid_ff, valid_in;
   rslt_type data_ff;
   logic     load;

   assign load     = ~valid_ff | out_ready;
   assign pop      = load & ~empty;
   assign valid_in = pop | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/substring_search_window_top.sv -----
// A result goes through the result queue, then the output register, to rsp_tvalid.
// Throughput: one haystack byte per cycle while the queue has room; the window shift
// and needle compare finish in the single front-end cycle in which the byte is taken.
// req_tready drops only when the four-entry result queue is full.
// Reset (synchronous, active high) clears the configuration registers, the byte
// counter, the match flag and the queue; the byte window keeps its contents.
// ----------------------------------------------------------------------------
// Substring search window top level
// Streams haystack bytes and reports the first occurrence of a configured
// needle of up to MAX_NEEDLE bytes, or that the haystack ended without one.
// ----------------------------------------------------------------------------
module substring_search_window_top import sss_pkg::*; #(
   parameter int MAX_NEEDLE  = MAX_NEEDLE_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // Haystack channel.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] hay_byte
   input  logic                     req_tlast,   // final_byte
   // Result channel.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // [15:0] match_offset
   output logic                     rsp_tuser,   // found
   // Configuration port.
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // The needle registers sit at byte addresses 0, 8, 16, 24 and 32. The user must
   // write them only while no haystack byte is in flight; the block does not enforce it.
   logic [LEN_BITS-1:0]    len_cfg;
   logic [NEEDLE_BITS-1:0] needle_vec;

   // Front end to queue, queue to back end.
   logic     push, full, pop, empty;
   rslt_type push_data, pop_data, out_data;

   sss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .len_cfg     (len_cfg),
      .needle_vec  (needle_vec)
   );

   // The front end takes every byte whose result can be queued. It holds the
   // window of recent bytes, the saturating byte counter and the flag that
   // mutes the rest of a haystack after its first match.
   sss_front #(
      .MAX_NEEDLE  (MAX_NEEDLE),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .len_cfg    (len_cfg),
      .needle_vec (needle_vec),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   // The queue lets the haystack keep flowing while a result waits to be taken.
   sss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // The back end presents one result item at a time from its output register.
   sss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.offset;
   assign rsp_tuser = out_data.found;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Substring search window testbench
// Streams haystacks through the block with random gaps on both channels. A
// scoreboard keeps its own window, byte counter and needle registers, works
// out the result of every accepted byte and checks each result item in order.
// The run covers a short directed part, a back-pressure phase and many random
// needle settings.
// ----------------------------------------------------------------------------
module tb_top;
   import sss_pkg::*;

   localparam int ITEM_TARGET   = 1950;     // accepted items before stopping
   localparam int CYCLE_LIMIT   = 1000000;  // generous ceiling for the whole run
   localparam int SETTLE_CYCLES = 4;        // block latency plus margin
   localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
   localparam int SPARE_REG_IDX = 5;        // no register lives at this index

   // -------------------------------------------------------------------------
   // Scoreboard: a bit-level copy of the search state. predict_byte() is fed
   // every accepted byte and queues the result it causes, if any;
   // compare_result() takes every accepted result item and checks it against
   // the oldest queued expectation.
   // -------------------------------------------------------------------------
   class match_scoreboard;
      logic [LEN_BITS-1:0]    len_reg;
      logic [NEEDLE_BITS-1:0] needle;
      logic [7:0]             window [MAX_NEEDLE_DEF];
      logic [15:0]            bytes_seen;
      bit                     reported;
      rslt_type               expected_matches [$];
      int                     errors;

      function new();
         len_reg    = '0;
         needle     = '0;
         bytes_seen = '0;
         reported   = 1'b0;
         errors     = 0;
         foreach (window[i]) window[i] = '0;
      endfunction

      function void write_reg(int unsigned idx, logic [WORD_BITS-1:0] value);
         unique case (idx)
            REG_NEEDLE_LEN:    len_reg = value[LEN_BITS-1:0];
            REG_NEEDLE_LO:     needle[63:0] = value;
            REG_NEEDLE_MID_LO: needle[127:64] = value;
            REG_NEEDLE_MID_HI: needle[191:128] = value;
            REG_NEEDLE_HI:     needle[255:192] = value;
            default: ;  // writes to unmapped indexes have no effect
         endcase
      endfunction

      function logic [WORD_BITS-1:0] reg_value(int unsigned idx);
         unique case (idx)
            REG_NEEDLE_LEN:    return {{(WORD_BITS-LEN_BITS){1'b0}}, len_reg};
            REG_NEEDLE_LO:     return needle[63:0];
            REG_NEEDLE_MID_LO: return needle[127:64];
            REG_NEEDLE_MID_HI: return needle[191:128];
            REG_NEEDLE_HI:     return needle[255:192];
            default:           return '0;
         endcase
      endfunction

      // Returns 1 when the byte took part in the search, 0 when it fell after
      // a match that was already reported.
      function bit predict_byte(logic [7:0] hay_byte, logic fin);
         int unsigned eff;
         int          i;
         bit          hit;
         rslt_type    r;
         eff = (len_reg > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : len_reg;
         if (reported) begin
            if (fin) begin
               bytes_seen = '0;
               reported   = 1'b0;
            end
            return 1'b0;
         end
         if (eff == 0) begin
            // An empty needle matches at once, without touching the window.
            r.found  = 1'b1;
            r.offset = '0;
            expected_matches.push_back(r);
            if (fin) bytes_seen = '0;
            else reported = 1'b1;
            return 1'b1;
         end
         for (i = MAX_NEEDLE_DEF - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = hay_byte;
         if (bytes_seen != 16'hFFFF) bytes_seen++;
         hit = (bytes_seen >= eff);
         for (i = 0; i < eff; i++) begin
            if (window[eff-1-i] != needle[i*8 +: 8]) hit = 1'b0;
         end
         if (hit) begin
            r.found  = 1'b1;
            r.offset = bytes_seen - 16'(eff);
            expected_matches.push_back(r);
            if (fin) bytes_seen = '0;
            else reported = 1'b1;
         end else if (fin) begin
            r.found  = 1'b0;
            r.offset = '0;
            expected_matches.push_back(r);
            bytes_seen = '0;
         end
         return 1'b1;
      endfunction

      function void compare_result(logic found, logic [15:0] offset);
         rslt_type want;
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual found %0b offset %0d",
                     $time, found, offset);
            errors++;
            return;
         end
         want = expected_matches.pop_front();
         if (found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, found);
            errors++;
         end
         if (offset !== want.offset) begin
            $display("%0t: offset mismatch, expected %0d, actual %0d",
                     $time, want.offset, offset);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_matches.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;    // [7:0] hay_byte
   logic                     req_tlast;    // final_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [15:0]              rsp_tdata;    // [15:0] match_offset
   logic                     rsp_tuser;    // found
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   match_scoreboard scoreboard;
   int  cycle_count   = 0;
   int  item_count    = 0;
   int  rsp_hold_req  = 0;   // set by the stimulus, consumed by the receiver
   bit  req_idle_on   = 1'b0;
   bit  rsp_idle_on   = 1'b0;

   substring_search_window_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The run is cut off if it hangs, for example when a result never comes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge, where every handshake
   // completes. Inputs only move at the falling edge, so the values read here
   // are the ones the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            void'(scoreboard.predict_byte(req_tdata, req_tlast));
            item_count++;
         end
         if (rsp_tvalid && rsp_tready) scoreboard.compare_result(rsp_tuser, rsp_tdata);
      end
   end

   // Receiver: before each result item it draws a wait, and it honors a
   // long hold-off when the stimulus asks for one.
   initial begin : result_sink
      int gap;
      int hold;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold         = rsp_hold_req;
            rsp_hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         gap = rsp_idle_on ? $urandom_range(0, 19) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks. Each one is entered at a falling edge and returns at a
   // falling edge at which it has assigned nothing yet.
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] hay_byte, input logic fin);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= hay_byte;
      req_tlast  <= fin;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // One APB write: setup cycle, access cycle, then a cycle with psel low so
   // that back-to-back writes never reassign psel within one time step.
   task automatic write_reg(input int unsigned idx, input logic [WORD_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(idx * 8);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      scoreboard.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Reads a register back and compares the bits it implements.
   task automatic check_reg(input int unsigned idx);
      logic [WORD_BITS-1:0] got;
      logic [WORD_BITS-1:0] want;
      logic [WORD_BITS-1:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_BITS'(idx * 8);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      want = scoreboard.reg_value(idx);
      mask = (idx == REG_NEEDLE_LEN) ? {{(WORD_BITS-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}} : '1;
      if ((got & mask) !== (want & mask)) begin
         $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                  $time, idx, want & mask, got & mask);
         scoreboard.errors++;
      end
   endtask

   // Stops offering bytes, waits for every expected result, then lets the
   // block settle, since a byte that causes no result may still be in flight.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [7:0]           needle_q [MAX_NEEDLE_DEF];
      logic [7:0]           alphabet [3];
      logic [7:0]           hay [$];
      logic [WORD_BITS-1:0] word;
      logic [LEN_BITS-1:0]  len_code;
      bit                   narrow;
      int                   eff;
      int                   pick;
      int                   kind;
      int                   hay_len;
      int                   pos;
      int                   n_hay;
      int                   w;
      int                   j;
      int                   k;

      scoreboard  = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. After reset the needle is empty, so the first byte of
      // a haystack matches at offset 0 and the rest of it is ignored.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h5A, 1'b1);
      wait_idle();

      // A write to an unmapped index must leave the needle alone. Then a
      // three-byte needle FF 00 FF.
      write_reg(SPARE_REG_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_NEEDLE_LEN, 64'd3);
      write_reg(REG_NEEDLE_LO, 64'h0000_0000_00FF_00FF);
      check_reg(REG_NEEDLE_LEN);
      check_reg(REG_NEEDLE_LO);
      // Match in the middle at offset 3; the trailing byte is ignored.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // A haystack shorter than the needle ends without a match.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // A match on the last byte gives only the hit, no miss after it.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h12, 1'b1);
      wait_idle();

      // Back-pressure: single-byte haystacks each cause a result while the
      // receiver holds off, so the result queue fills and req_tready drops.
      write_reg(REG_NEEDLE_LEN, 64'd1);
      write_reg(REG_NEEDLE_LO, 64'h41);
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      rsp_hold_req = HOLD_CYCLES;
      for (j = 0; j < 24; j++) send_byte($urandom_range(0, 1) ? 8'h41 : 8'h42, 1'b1);
      wait_idle();

      // Random part, in phases. Each phase picks a needle, an alphabet and
      // the idle behavior of both sides, then sends a few whole haystacks.
      while (item_count < ITEM_TARGET) begin
         narrow = ($urandom_range(0, 3) != 0);
         for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 15);
         unique case (pick)
            0:       len_code = '0;
            1:       len_code = LEN_BITS'(MAX_NEEDLE_DEF);
            2:       len_code = LEN_BITS'($urandom_range(MAX_NEEDLE_DEF + 1, 63));
            3:       len_code = LEN_BITS'(1);
            4, 5, 6, 7, 8, 9: len_code = LEN_BITS'($urandom_range(2, 8));
            default: len_code = LEN_BITS'($urandom_range(1, MAX_NEEDLE_DEF));
         endcase
         eff = (len_code > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : len_code;
         for (k = 0; k < MAX_NEEDLE_DEF; k++) begin
            needle_q[k] = narrow ? alphabet[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
         end

         // The length register only keeps its low bits; the rest is noise.
         word = {$urandom, $urandom};
         word[LEN_BITS-1:0] = len_code;
         write_reg(REG_NEEDLE_LEN, word);
         for (w = 0; w < 4; w++) begin
            for (k = 0; k < 8; k++) word[k*8 +: 8] = needle_q[w*8 + k];
            write_reg(REG_NEEDLE_LO + w, word);
         end
         if ($urandom_range(0, 7) == 0) write_reg(SPARE_REG_IDX, {$urandom, $urandom});
         for (w = 0; w < 5; w++) check_reg(w);

         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);

         n_hay = $urandom_range(3, 8);
         repeat (n_hay) begin
            hay.delete();
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
               // Well-formed: bytes from the needle's alphabet, usually with
               // the needle planted, sometimes a copy with one bit flipped.
               hay_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80)
                                                     : $urandom_range(1, eff + 10);
               for (j = 0; j < hay_len; j++) begin
                  hay.push_back(narrow ? alphabet[$urandom_range(0, 2)]
                                       : 8'($urandom_range(0, 255)));
               end
               if (eff > 0 && hay_len >= eff && $urandom_range(0, 3) != 0) begin
                  pos = $urandom_range(0, hay_len - eff);
                  for (k = 0; k < eff; k++) hay[pos + k] = needle_q[k];
                  if (kind == 7) begin
                     k = pos + $urandom_range(0, eff - 1);
                     hay[k] = hay[k] ^ (8'h01 << $urandom_range(0, 7));
                  end
               end
            end else begin
               // Noise: short haystacks of arbitrary bytes.
               hay_len = $urandom_range(1, 20);
               for (j = 0; j < hay_len; j++) hay.push_back(8'($urandom_range(0, 255)));
            end
            for (j = 0; j < hay.size(); j++) send_byte(hay[j], j == hay.size() - 1);
         end
         wait_idle();
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (scoreboard.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/sss_pkg.sv
sv/sss_csr.sv
sv/sss_front.sv
sv/sss_queue.sv
sv/sss_back.sv
sv/substring_search_window_top.sv
sim/tb_top.sv
